>>> rtl/assert_macros.svh
// assertion macros shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/csvtok_pkg.sv
// shared types, codes and constants of the csv tokenizer
package csvtok_pkg;

   localparam int LINE_BITS_DEFAULT = 16;

   // character codes
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // result kinds
   localparam logic [2:0] KIND_DATA        = 3'd0;
   localparam logic [2:0] KIND_FIELD_END   = 3'd1;
   localparam logic [2:0] KIND_RECORD_END  = 3'd2;
   localparam logic [2:0] KIND_DONE        = 3'd3;
   localparam logic [2:0] KIND_QUOTE_ERR   = 3'd4;
   localparam logic [2:0] KIND_UNCLOSED    = 3'd5;

   // result queue
   localparam int RES_DEPTH    = 4;
   localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
   localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

   typedef enum logic [2:0] {
      QM_UNQUOTED   = 3'b001,
      QM_IN_QUOTES  = 3'b010,
      QM_QUOTE_SEEN = 3'b100
   } quote_mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  character_res;
      logic [15:0] line_number;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

>>> rtl/csv_quoted_field_tokenizer_top.sv
// top level of the streaming csv tokenizer
// a character's result beats enter a registered result queue when it is taken
// one character per cycle while req_ready is high; end of input may give two
// beats, which drain one per cycle while rsp_ready is high, from a four-beat
// result queue; request ready drops only while it holds more than two beats
// synchronous reset clears parser state to line 1 and empties the queue
module csv_quoted_field_tokenizer_top #(
   parameter int LINE_BITS = csvtok_pkg::LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_character_res,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last
);

   logic                   accept;
   csvtok_pkg::step_type   step;
   csvtok_pkg::result_type beat;

   assign accept = req_valid && req_ready;

   csvtok_parser #(
      .LINE_BITS(LINE_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .end_of_input (req_end_of_input),
      .step         (step)
   );

   csvtok_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (beat)
   );

   assign rsp_kind          = beat.kind;
   assign rsp_character_res = beat.character_res;
   assign rsp_line_number   = beat.line_number;
   assign rsp_last          = beat.last;

endmodule

>>> rtl/csvtok_parser.sv
// parser state and the per-character step logic
`include "assert_macros.svh"

module csvtok_parser #(
   parameter int LINE_BITS = csvtok_pkg::LINE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           character,
   input  logic                 end_of_input,
   output csvtok_pkg::step_type step
);

   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   csvtok_pkg::quote_mode_type qm_ff, qm_in;
   logic                       cr_pending_ff, cr_pending_in;
   logic                       field_content_ff, field_content_in;
   logic                       record_fields_ff, record_fields_in;
   logic                       halted_ff, halted_in;
   logic [LINE_BITS-1:0]       line_ff, line_in;

   logic [31:0] line_wide;
   logic [15:0] line16;

   assign line_wide = 32'(line_ff);
   assign line16    = (line_wide > 32'h0000_FFFF) ? 16'hFFFF : line_wide[15:0];

   always_comb begin
      logic                       swallow;
      logic                       unquoted;
      logic [LINE_BITS-1:0]       line_bumped;
      csvtok_pkg::result_type     r0;
      csvtok_pkg::result_type     r1;
      logic [1:0]                 n;

      qm_in            = qm_ff;
      cr_pending_in    = cr_pending_ff;
      field_content_in = field_content_ff;
      record_fields_in = record_fields_ff;
      halted_in        = halted_ff;
      line_in          = line_ff;
      swallow          = 1'b0;
      unquoted         = 1'b1;
      line_bumped      = (line_ff != LINE_MAX) ? line_ff + LINE_ONE : line_ff;
      r0               = '{kind: csvtok_pkg::KIND_DATA, character_res: 8'd0,
                           line_number: line16, last: 1'b0};
      r1               = r0;
      n                = 2'd0;

      if (end_of_input) begin
         if (!halted_ff) begin
            if (qm_ff == csvtok_pkg::QM_IN_QUOTES) begin
               r0.kind = csvtok_pkg::KIND_UNCLOSED;
               n       = 2'd1;
            end else if (field_content_ff || record_fields_ff) begin
               r0.kind = csvtok_pkg::KIND_RECORD_END;
               r1.kind = csvtok_pkg::KIND_DONE;
               n       = 2'd2;
            end else begin
               r0.kind = csvtok_pkg::KIND_DONE;
               n       = 2'd1;
            end
         end
         qm_in            = csvtok_pkg::QM_UNQUOTED;
         cr_pending_in    = 1'b0;
         field_content_in = 1'b0;
         record_fields_in = 1'b0;
         halted_in        = 1'b0;
         line_in          = LINE_ONE;
      end else if (!halted_ff) begin
         cr_pending_in = 1'b0;
         // lf right after an unquoted cr
         if (cr_pending_ff && character == csvtok_pkg::CH_LF) begin
            swallow = 1'b1;
         end
         if (!swallow && qm_ff == csvtok_pkg::QM_QUOTE_SEEN) begin
            if (character == csvtok_pkg::CH_QUOTE) begin
               // doubled quote gives a literal quote
               r0.character_res = csvtok_pkg::CH_QUOTE;
               n                = 2'd1;
               field_content_in = 1'b1;
               qm_in            = csvtok_pkg::QM_IN_QUOTES;
               swallow          = 1'b1;
            end else begin
               qm_in = csvtok_pkg::QM_UNQUOTED;
            end
         end
         if (!swallow && qm_ff == csvtok_pkg::QM_IN_QUOTES) begin
            unquoted = 1'b0;
            if (character == csvtok_pkg::CH_QUOTE) begin
               qm_in = csvtok_pkg::QM_QUOTE_SEEN;
            end else begin
               r0.character_res = character;
               n                = 2'd1;
               field_content_in = 1'b1;
               if (character == csvtok_pkg::CH_LF) begin
                  line_in = line_bumped;
               end
            end
         end
         if (!swallow && unquoted) begin
            priority if (character == csvtok_pkg::CH_COMMA) begin
               r0.kind          = csvtok_pkg::KIND_FIELD_END;
               n                = 2'd1;
               record_fields_in = 1'b1;
               field_content_in = 1'b0;
            end else if (character == csvtok_pkg::CH_QUOTE) begin
               if (field_content_ff) begin
                  r0.kind   = csvtok_pkg::KIND_QUOTE_ERR;
                  n         = 2'd1;
                  halted_in = 1'b1;
               end else begin
                  qm_in = csvtok_pkg::QM_IN_QUOTES;
               end
            end else if (character == csvtok_pkg::CH_CR || character == csvtok_pkg::CH_LF) begin
               // blank records give no record end
               if (field_content_ff || record_fields_ff) begin
                  r0.kind = csvtok_pkg::KIND_RECORD_END;
                  n       = 2'd1;
               end
               field_content_in = 1'b0;
               record_fields_in = 1'b0;
               qm_in            = csvtok_pkg::QM_UNQUOTED;
               cr_pending_in    = (character == csvtok_pkg::CH_CR);
               line_in          = line_bumped;
            end else begin
               r0.character_res = character;
               n                = 2'd1;
               field_content_in = 1'b1;
            end
         end
      end

      if (n == 2'd2) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
      step.count  = n;
      step.first  = r0;
      step.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qm_ff            <= csvtok_pkg::QM_UNQUOTED;
         cr_pending_ff    <= 1'b0;
         field_content_ff <= 1'b0;
         record_fields_ff <= 1'b0;
         halted_ff        <= 1'b0;
         line_ff          <= LINE_ONE;
      end else if (accept) begin
         qm_ff            <= qm_in;
         cr_pending_ff    <= cr_pending_in;
         field_content_ff <= field_content_in;
         record_fields_ff <= record_fields_in;
         halted_ff        <= halted_in;
         line_ff          <= line_in;
      end
   end

   `ASSERT_HOLDS(a_two_only_at_end, clock, reset,
      (accept && step.count == 2'd2) |-> end_of_input, "two beats from a character")
   `ASSERT_HOLDS(a_halted_silent, clock, reset,
      (accept && halted_ff && !end_of_input) |-> (step.count == 2'd0),
      "output while halted")
   `ASSERT_HOLDS(a_error_halts, clock, reset,
      (accept && !end_of_input && step.count != 2'd0 &&
       step.first.kind == csvtok_pkg::KIND_QUOTE_ERR) |=> halted_ff,
      "quote error did not halt parser")

endmodule

>>> rtl/csvtok_result_fifo.sv
// small result queue that takes up to two beats per cycle and returns one while out_ready is high
`include "assert_macros.svh"

module csvtok_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  csvtok_pkg::step_type   step,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output csvtok_pkg::result_type out_beat
);

   localparam int D  = csvtok_pkg::RES_DEPTH;
   localparam int PB = csvtok_pkg::RES_PTR_BITS;
   localparam int CB = csvtok_pkg::RES_CNT_BITS;

   csvtok_pkg::result_type entry_ff [D];
   logic [PB-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0]          count_ff, count_in;
   logic [1:0]             push_n;
   logic                   pop;
   logic [PB-1:0]          wr_next;

   assign push_n    = push ? step.count : 2'd0;
   assign pop       = out_valid && out_ready;
   assign space     = (count_ff <= CB'(D - 2));
   assign out_valid = (count_ff != '0);
   assign out_beat  = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + PB'(1);

   assign wr_ptr_in = wr_ptr_ff + PB'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PB'(pop);
   assign count_in  = count_ff + CB'(push_n) - CB'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= step.first;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_next] <= step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CB'(D), "queue count past depth")
   `ASSERT_NEVER(a_no_overflow, clock, reset,
      (push_n != 2'd0) && (count_ff > CB'(D - 2)), "push without room")
   `ASSERT_HOLDS(a_pop_drains, clock, reset,
      (pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - CB'(1)),
      "pop did not drain one beat")

endmodule

>>> tb/tb_csv_quoted_field_tokenizer_top.sv
// self-checking testbench for the streaming csv tokenizer

class csv_token_tracker_type;
   csvtok_pkg::result_type     expected_tokens[$];
   csvtok_pkg::quote_mode_type quote_state;
   bit             cr_seen;
   bit             field_open;
   bit             record_open;
   bit             halted;
   int unsigned    line_count;
   int unsigned    line_max;
   int unsigned    mismatches;
   int unsigned    tokens_checked;
   int unsigned    live_items;
   int unsigned    char_items;
   int unsigned    eoi_items;
   int unsigned    kinds_seen[8];

   function new(int unsigned max_line);
      line_max = max_line;
      clear_parser();
   endfunction

   function void clear_parser();
      quote_state = csvtok_pkg::QM_UNQUOTED;
      cr_seen     = 1'b0;
      field_open  = 1'b0;
      record_open = 1'b0;
      halted      = 1'b0;
      line_count  = 1;
   endfunction

   function void bump_line();
      if (line_count < line_max) line_count++;
   endfunction

   function csvtok_pkg::result_type make_token(logic [2:0] kind, logic [7:0] c,
                                               logic [15:0] ln);
      csvtok_pkg::result_type t;
      t.kind          = kind;
      t.character_res = c;
      t.line_number   = ln;
      t.last          = 1'b0;
      return t;
   endfunction

   // note one accepted input beat and queue the result beats it should cause
   function void note_input(logic [7:0] c, logic eoi);
      csvtok_pkg::result_type  batch[$];
      csvtok_pkg::result_type  t;
      logic [15:0] ln;
      bit          taken;
      ln = (line_count > 32'hFFFF) ? 16'hFFFF : line_count[15:0];
      taken = 1'b0;
      if (eoi || !halted) live_items++;
      if (eoi) eoi_items++;
      else char_items++;
      if (eoi) begin
         if (!halted) begin
            if (quote_state == csvtok_pkg::QM_IN_QUOTES) begin
               batch.push_back(make_token(csvtok_pkg::KIND_UNCLOSED, 8'h00, ln));
            end else begin
               if (field_open || record_open)
                  batch.push_back(make_token(csvtok_pkg::KIND_RECORD_END, 8'h00, ln));
               batch.push_back(make_token(csvtok_pkg::KIND_DONE, 8'h00, ln));
            end
         end
         clear_parser();
      end else if (!halted) begin
         if (cr_seen) begin
            cr_seen = 1'b0;
            if (c == csvtok_pkg::CH_LF) taken = 1'b1;
         end
         if (!taken && quote_state == csvtok_pkg::QM_QUOTE_SEEN) begin
            if (c == csvtok_pkg::CH_QUOTE) begin
               // doubled quote inside quotes
               batch.push_back(make_token(csvtok_pkg::KIND_DATA, csvtok_pkg::CH_QUOTE, ln));
               field_open  = 1'b1;
               quote_state = csvtok_pkg::QM_IN_QUOTES;
               taken       = 1'b1;
            end else begin
               quote_state = csvtok_pkg::QM_UNQUOTED;
            end
         end
         if (!taken) begin
            if (quote_state == csvtok_pkg::QM_IN_QUOTES) begin
               if (c == csvtok_pkg::CH_QUOTE) begin
                  quote_state = csvtok_pkg::QM_QUOTE_SEEN;
               end else begin
                  batch.push_back(make_token(csvtok_pkg::KIND_DATA, c, ln));
                  field_open = 1'b1;
                  if (c == csvtok_pkg::CH_LF) bump_line();
               end
            end else if (c == csvtok_pkg::CH_COMMA) begin
               batch.push_back(make_token(csvtok_pkg::KIND_FIELD_END, 8'h00, ln));
               record_open = 1'b1;
               field_open  = 1'b0;
            end else if (c == csvtok_pkg::CH_QUOTE) begin
               if (field_open) begin
                  batch.push_back(make_token(csvtok_pkg::KIND_QUOTE_ERR, 8'h00, ln));
                  halted = 1'b1;
               end else begin
                  quote_state = csvtok_pkg::QM_IN_QUOTES;
               end
            end else if (c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF) begin
               // blank records give no record end but still count a line
               if (field_open || record_open)
                  batch.push_back(make_token(csvtok_pkg::KIND_RECORD_END, 8'h00, ln));
               field_open  = 1'b0;
               record_open = 1'b0;
               quote_state = csvtok_pkg::QM_UNQUOTED;
               if (c == csvtok_pkg::CH_CR) cr_seen = 1'b1;
               bump_line();
            end else begin
               batch.push_back(make_token(csvtok_pkg::KIND_DATA, c, ln));
               field_open = 1'b1;
            end
         end
      end
      foreach (batch[i]) begin
         t = batch[i];
         t.last = (i == batch.size() - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   function void check_result(logic [2:0] kind, logic [7:0] c, logic [15:0] ln, logic last);
      csvtok_pkg::result_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: result beat with nothing expected: kind %0d char %02h line %0d last %0b",
                  $time, kind, c, ln, last);
         mismatches++;
         return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      kinds_seen[kind]++;
      if (kind !== want.kind) begin
         $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
         mismatches++;
      end
      if (c !== want.character_res) begin
         $display("%0t: character expected %02h actual %02h", $time, want.character_res, c);
         mismatches++;
      end
      if (ln !== want.line_number) begin
         $display("%0t: line expected %0d actual %0d", $time, want.line_number, ln);
         mismatches++;
      end
      if (last !== want.last) begin
         $display("%0t: last expected %0b actual %0b", $time, want.last, last);
         mismatches++;
      end
   endfunction
endclass

module tb_csv_quoted_field_tokenizer_top;

   localparam int LINE_BITS     = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 560;
   localparam int HOLD_CYCLES   = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_character_res;
   logic [15:0] rsp_line_number;
   logic        rsp_last;

   csv_token_tracker_type tracker = new((1 << LINE_BITS) - 1);

   logic [7:0]  text_q[$];
   int unsigned send_idle_pct = 36;
   int unsigned rsp_idle_pct = 36;
   logic        hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   csv_quoted_field_tokenizer_top #(
      .LINE_BITS(LINE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_character_res(rsp_character_res),
      .rsp_line_number  (rsp_line_number),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: check each beat taken, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_kind, rsp_character_res, rsp_line_number, rsp_last);
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_beat(input logic [7:0] c, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_character    <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      tracker.note_input(c, eoi);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_beat(text_q[i], 1'b0);
      text_q.delete();
      // the character lane is don't-care on an end-of-input beat
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == csvtok_pkg::CH_QUOTE || c == csvtok_pkg::CH_COMMA ||
             c == csvtok_pkg::CH_CR || c == csvtok_pkg::CH_LF);
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 7))
         0: return csvtok_pkg::CH_QUOTE;
         1: return csvtok_pkg::CH_COMMA;
         2: return csvtok_pkg::CH_CR;
         3: return csvtok_pkg::CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_line_break();
      case ($urandom_range(0, 2))
         0: text_q.push_back(csvtok_pkg::CH_CR);
         1: text_q.push_back(csvtok_pkg::CH_LF);
         default: begin
            text_q.push_back(csvtok_pkg::CH_CR);
            text_q.push_back(csvtok_pkg::CH_LF);
         end
      endcase
   endtask

   task automatic add_field();
      if ($urandom_range(0, 2) == 0) begin
         text_q.push_back(csvtok_pkg::CH_QUOTE);
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 9))
               0: begin
                  text_q.push_back(csvtok_pkg::CH_QUOTE);
                  text_q.push_back(csvtok_pkg::CH_QUOTE);
               end
               1: text_q.push_back(csvtok_pkg::CH_COMMA);
               2: text_q.push_back(csvtok_pkg::CH_CR);
               3: text_q.push_back(csvtok_pkg::CH_LF);
               default: text_q.push_back(plain_char());
            endcase
         end
         text_q.push_back(csvtok_pkg::CH_QUOTE);
      end else begin
         repeat ($urandom_range(0, 4)) text_q.push_back(plain_char());
      end
   endtask

   // mostly well-formed records, some with noise, a stray quote or an open quote
   task automatic build_document();
      int shape;
      int records;
      int fields;
      shape   = $urandom_range(0, 9);
      records = $urandom_range(1, 4);
      for (int r = 0; r < records; r++) begin
         if ($urandom_range(0, 7) == 0) add_line_break();
         fields = $urandom_range(1, 4);
         for (int f = 0; f < fields; f++) begin
            if (f != 0) text_q.push_back(csvtok_pkg::CH_COMMA);
            add_field();
         end
         if (r != records - 1 || $urandom_range(0, 1)) add_line_break();
      end
      case (shape)
         7: repeat ($urandom_range(1, 12)) text_q.push_back(noise_char());
         8: begin
            text_q.push_back(plain_char());
            text_q.push_back(csvtok_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 6)) text_q.push_back(noise_char());
         end
         9: begin
            add_line_break();
            text_q.push_back(csvtok_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) text_q.push_back(plain_char());
         end
         default: ;
      endcase
   endtask

   initial begin
      int unsigned random_start;
      int unsigned doc_index;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, quoted comma and line feed, doubled quote, crlf,
      // blank line, quoted empty field alone, stray quote then ignored text
      text_q = {8'h00, 8'hFF, csvtok_pkg::CH_COMMA, csvtok_pkg::CH_QUOTE,
                csvtok_pkg::CH_COMMA, csvtok_pkg::CH_LF, csvtok_pkg::CH_QUOTE,
                csvtok_pkg::CH_QUOTE, 8'h41, csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_CR,
                csvtok_pkg::CH_LF, csvtok_pkg::CH_LF, csvtok_pkg::CH_QUOTE,
                csvtok_pkg::CH_QUOTE, csvtok_pkg::CH_LF, 8'h71, csvtok_pkg::CH_QUOTE,
                8'h7A};
      send_text();
      // quote left open at end of input
      text_q = {csvtok_pkg::CH_QUOTE, 8'h61};
      send_text();
      // lone cr followed by data, then a flush of the open record
      text_q = {8'h62, csvtok_pkg::CH_CR, 8'h63};
      send_text();
      // end of input with nothing before it
      send_text();

      random_start = tracker.live_items;
      doc_index = 0;
      while (tracker.live_items - random_start < RANDOM_ITEMS) begin
         if (doc_index == 4) hold_armed <= 1'b1;
         if (doc_index == 8) wait_drained();
         if (doc_index >= 12 && doc_index < 20) begin
            send_idle_pct = 0;
            rsp_idle_pct <= 0;
         end else begin
            send_idle_pct = 36;
            rsp_idle_pct <= 36;
         end
         build_document();
         send_text();
         doc_index++;
      end

      // a last one-character record
      text_q = {8'h6B};
      send_text();

      req_valid <= 1'b0;
      while (tracker.expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d characters, %0d end-of-input beats, %0d random documents,",
               tracker.char_items, tracker.eoi_items, doc_index);
      $display("results checked: %0d data, %0d field, %0d record, %0d done, %0d error",
               tracker.kinds_seen[csvtok_pkg::KIND_DATA],
               tracker.kinds_seen[csvtok_pkg::KIND_FIELD_END],
               tracker.kinds_seen[csvtok_pkg::KIND_RECORD_END],
               tracker.kinds_seen[csvtok_pkg::KIND_DONE],
               tracker.kinds_seen[csvtok_pkg::KIND_QUOTE_ERR] +
               tracker.kinds_seen[csvtok_pkg::KIND_UNCLOSED]);
      if (tracker.mismatches == 0 && tracker.expected_tokens.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
